[sv/ita_pkg.sv]
// Shared types, constants and the digit-to-ASCII function for the integer-to-ASCII block.
// No dependencies. Used by ita_cell.sv and integer_to_ascii_digits.sv.
package ita_pkg;

	// Mode codes on the input channel
	localparam logic [2:0] MODE_SDEC = 3'd0;
	localparam logic [2:0] MODE_UDEC = 3'd1;
	localparam logic [2:0] MODE_OCT  = 3'd2;
	localparam logic [2:0] MODE_LHEX = 3'd3;
	localparam logic [2:0] MODE_UHEX = 3'd4;

	// Digit cells in the row: 11 octal digits cover 32 bits
	localparam int NCELL     = 11;
	localparam int CNT_W     = $clog2(NCELL + 1);
	localparam int VAL_W     = 32;
	localparam int BITCNT_W  = $clog2(VAL_W);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_UA    = 8'h41;

	typedef enum logic [1:0] {
		RADIX_DEC,
		RADIX_OCT,
		RADIX_HEX
	} radix_t;

	// Control broadcast from the sequencer to every cell
	typedef struct packed {
		logic   clear;
		logic   bit_shift;
		logic   digit_shift;
		radix_t radix;
	} cell_ctrl_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + {4'd0, d};
		end else begin
			c = {4'd0, d} - 8'd10 + (upper ? CHAR_UA : CHAR_LA);
		end
		return c;
	endfunction

endpackage

[sv/ita_cell.sv]
// One digit cell of the conversion row: shift-and-correct for decimal, plain shift for
// octal and hex, whole-digit shift toward the top for emission. Depends on ita_pkg.
module ita_cell (
	input  logic               clk,
	input  ita_pkg::cell_ctrl_t ctrl,
	input  logic               bit_in,
	input  logic [3:0]         digit_in,
	output logic               bit_out,
	output logic [3:0]         digit_q
);
	import ita_pkg::*;

	logic [3:0] adj;

	// add-3 correction before the shift keeps decimal digits in 0..9
	always_comb begin
		adj = digit_q;
		if (ctrl.radix == RADIX_DEC && digit_q >= 4'd5) begin
			adj = digit_q + 4'd3;
		end
		case (ctrl.radix)
			RADIX_OCT: bit_out = digit_q[2];
			default:   bit_out = adj[3];
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= 4'd0;
		end else if (ctrl.bit_shift) begin
			case (ctrl.radix)
				RADIX_OCT: digit_q <= {1'b0, digit_q[1:0], bit_in};
				default:   digit_q <= {adj[2:0], bit_in};
			endcase
		end else if (ctrl.digit_shift) begin
			digit_q <= digit_in;
		end
	end

endmodule

[sv/integer_to_ascii_digits.sv]
// Integer to ASCII digits: the value is shifted bit by bit, MSB first, through the digit-cell
// row, then the digits leave the top cell one at a time, with a minus sign first when negative;
// leading zero positions are scanned without output, and an output stall holds emission.
// A new input transfer is taken only once the previous item's last character has been
// loaded into the output register. Reset (arst_n low, asynchronous) empties the output
// and returns to idle. Depends on ita_pkg and ita_cell.
module integer_to_ascii_digits (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [31:0] value,
	input  logic [2:0] mode,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] character,
	output logic       last
);
	import ita_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [VAL_W-1:0]      mag_q;       // magnitude, fed into the row MSB first
	logic [BITCNT_W-1:0]   bit_cnt_q;
	logic [CNT_W-1:0]      dig_cnt_q;   // digit positions not yet scanned
	logic                  neg_q;
	logic                  upper_q;
	radix_t                radix_q;
	logic                  started_q;   // first nonzero digit already sent
	logic                  out_valid_q;
	logic [7:0]            character_q;
	logic                  last_q;

	cell_ctrl_t            ctrl;
	logic [NCELL-1:0]      bit_out;
	logic [3:0]            digit [NCELL];
	logic [3:0]            top_digit;
	logic                  adv_ok;
	logic                  emit_now;
	logic                  skip_now;
	logic                  sign_now;
	logic                  accept;
	radix_t                radix_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign character = character_q;
	assign last      = last_q;

	// output register can take a new character this cycle
	assign adv_ok    = !out_valid_q || out_ready;
	assign top_digit = digit[NCELL-1];
	// leading zeros are dropped, except the units position which always goes out
	assign emit_now  = (state_q == ST_EMIT) && adv_ok &&
		(started_q || top_digit != 4'd0 || dig_cnt_q == CNT_W'(1));
	assign skip_now  = (state_q == ST_EMIT) && !started_q &&
		top_digit == 4'd0 && dig_cnt_q != CNT_W'(1);
	assign sign_now  = (state_q == ST_SIGN) && adv_ok;

	always_comb begin
		case (mode)
			MODE_OCT:             radix_d = RADIX_OCT;
			MODE_LHEX, MODE_UHEX: radix_d = RADIX_HEX;
			default:              radix_d = RADIX_DEC;
		endcase
	end

	always_comb begin
		ctrl.clear       = accept;
		ctrl.bit_shift   = (state_q == ST_CONV);
		ctrl.digit_shift = emit_now || skip_now;
		ctrl.radix       = radix_q;
	end

	// Cell row: bits ripple up one cell per shift during conversion, whole digits move
	// up one cell per step during emission; the top cell feeds the output.
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		logic       b_in;
		logic [3:0] d_in;
		if (i == 0) begin : g_first
			assign b_in = mag_q[VAL_W-1];
			assign d_in = 4'd0;
		end else begin : g_next
			assign b_in = bit_out[i-1];
			assign d_in = digit[i-1];
		end
		ita_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.bit_in   (b_in),
			.digit_in (d_in),
			.bit_out  (bit_out[i]),
			.digit_q  (digit[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_cnt_q   <= '0;
			dig_cnt_q   <= '0;
			neg_q       <= 1'b0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
			upper_q     <= 1'b0;
			radix_q     <= RADIX_DEC;
		end else begin
			// drained and not refilled this cycle
			if (out_valid_q && out_ready && !emit_now && !sign_now) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						// most negative value wraps to its true magnitude
						neg_q     <= (mode == MODE_SDEC) && value[VAL_W-1];
						mag_q     <= ((mode == MODE_SDEC) && value[VAL_W-1]) ?
							(32'd0 - value) : value;
						radix_q   <= radix_d;
						upper_q   <= (mode == MODE_UHEX);
						bit_cnt_q <= '0;
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					mag_q     <= {mag_q[VAL_W-2:0], 1'b0};
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == BITCNT_W'(VAL_W - 1)) begin
						dig_cnt_q <= CNT_W'(NCELL);
						started_q <= 1'b0;
						state_q   <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (sign_now) begin
						out_valid_q <= 1'b1;
						character_q <= CHAR_MINUS;
						last_q      <= 1'b0;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_now) begin
						out_valid_q <= 1'b1;
						character_q <= digit_char(top_digit, upper_q);
						last_q      <= (dig_cnt_q == CNT_W'(1));
						started_q   <= 1'b1;
						dig_cnt_q   <= dig_cnt_q - 1'b1;
						if (dig_cnt_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end else if (skip_now) begin
						dig_cnt_q <= dig_cnt_q - 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// no carry ever leaves the top cell: the row is wide enough for any radix
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> !bit_out[NCELL-1])
		else $error("digit row overflow");

	// the scan count never runs out while digits remain to be sent
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (dig_cnt_q != '0))
		else $error("digit count exhausted in emit");

	// an input transfer starts a fresh conversion
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CONV) && (bit_cnt_q == '0))
		else $error("conversion did not start");

	// a sign character never ends a run
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && character == CHAR_MINUS) |-> !last)
		else $error("minus flagged as last");

endmodule
